// ----- hdl/svn_pkg.sv -----
// softmax normalizer package: sizes, exp table, shared struct
// no dependencies
package svn_pkg;
    localparam int MaxElems = 32;
    localparam int IdxW = $clog2(MaxElems);
    localparam int CntW = $clog2(MaxElems + 1);
    localparam int SumW = 22;
    localparam int QDepth = 2;

    typedef struct packed {
        logic [15:0] value;
        logic        stored;
        logic        last;
    } front_item_t;

    function automatic logic [15:0] exp_lut(input logic [3:0] j);
        logic [15:0] r;
        unique case (j)
            4'd0: r = 16'd65535;
            4'd1: r = 16'd62757;
            4'd2: r = 16'd60097;
            4'd3: r = 16'd57549;
            4'd4: r = 16'd55109;
            4'd5: r = 16'd52773;
            4'd6: r = 16'd50535;
            4'd7: r = 16'd48393;
            4'd8: r = 16'd46341;
            4'd9: r = 16'd44376;
            4'd10: r = 16'd42495;
            4'd11: r = 16'd40693;
            4'd12: r = 16'd38968;
            4'd13: r = 16'd37316;
            4'd14: r = 16'd35734;
            default: r = 16'd34219;
        endcase
        return r;
    endfunction
endpackage

// ----- hdl/svn_if.sv -----
// valid/ready channel interfaces for the softmax normalizer
// no dependencies
interface svn_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] value;
    logic               last;
    modport source (output valid, value, last, input ready);
    modport sink (input valid, value, last, output ready);
endinterface

interface svn_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] prob;
    logic        final_res;
    logic        overflowed;
    modport source (output valid, prob, final_res, overflowed, input ready);
    modport sink (input valid, prob, final_res, overflowed, output ready);
endinterface

// ----- hdl/svn_ram.sv -----
// generic single-port-write, registered-read ram
// no dependencies
module svn_ram #(
    parameter int Width = 16,
    parameter int Depth = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/svn_front.sv -----
// front end: takes elements, decides store or drop, fills the queue
// depends on svn_pkg, svn_if
module svn_front
    import svn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    svn_in_if.sink       in_ch,
    input  logic         vec_done,
    output logic         q_push,
    output front_item_t  q_item,
    input  logic         q_full
);
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;

    // one vector at a time: hold off after a last element until the back end finishes
    assign in_ch.ready = !q_full && !busy_reg;
    assign q_push = in_ch.valid && in_ch.ready;
    assign q_item.value = in_ch.value;
    assign q_item.stored = cnt_reg < CntW'(MaxElems);
    assign q_item.last = in_ch.last;

    always_comb
    begin
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (q_push)
        begin
            if (in_ch.last)
            begin
                cnt_next = '0;
                busy_next = 1'b1;
            end
            else if (q_item.stored)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (vec_done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
        end
    end
endmodule

// ----- hdl/svn_queue.sv -----
// short fifo between front and back end
// depends on svn_pkg
module svn_queue
    import svn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  front_item_t push_item,
    output logic        full,
    input  logic        pop,
    output front_item_t pop_item,
    output logic        not_empty
);
    localparam int PtrW = $clog2(QDepth);
    front_item_t      slot_reg [QDepth];
    logic [PtrW-1:0]  wp_reg, rp_reg;
    logic [PtrW:0]    fill_reg;

    assign full = fill_reg == (PtrW+1)'(QDepth);
    assign not_empty = fill_reg != '0;
    assign pop_item = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            fill_reg <= fill_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end
endmodule

// ----- hdl/svn_back.sv -----
// back end: element store, running max, exp pass, sum, divide pass
// depends on svn_pkg, svn_if, svn_ram
module svn_back
    import svn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  front_item_t  q_item,
    output logic         q_pop,
    output logic         vec_done,
    svn_out_if.source    out_ch
);
    localparam logic [2:0] StLoad = 3'd0;
    localparam logic [2:0] StExpRd = 3'd1;
    localparam logic [2:0] StExpCalc = 3'd2;
    localparam logic [2:0] StDivRd = 3'd3;
    localparam logic [2:0] StDiv = 3'd4;
    localparam logic [2:0] StEmit = 3'd5;
    localparam logic [2:0] StExpMul = 3'd6;
    localparam logic [2:0] StDivLd = 3'd7;

    logic [2:0]         st_reg;
    logic [CntW-1:0]    cnt_reg;
    logic [IdxW-1:0]    idx_reg;
    logic signed [15:0] max_reg;
    logic [SumW-1:0]    sum_reg;
    logic               drop_reg;
    logic [31:0]        n369_reg;

    // divider state
    logic [5:0]         dstep_reg;
    logic [SumW:0]      rem_reg;
    logic [37:0]        dnum_reg;
    logic [16:0]        quo_reg;

    logic [15:0]        prob_reg;
    logic               fin_reg;
    logic               ovf_reg;
    logic               oval_reg;

    // memories
    logic               el_we;
    logic [IdxW-1:0]    el_waddr;
    logic [15:0]        el_rdata;
    logic               ex_we;
    logic [15:0]        ex_wdata;
    logic [15:0]        ex_rdata;

    svn_ram #(.Width(16), .Depth(MaxElems)) u_el (
        .clk(clk), .we(el_we), .waddr(el_waddr), .wdata(q_item.value),
        .raddr(idx_reg), .rdata(el_rdata)
    );
    svn_ram #(.Width(16), .Depth(MaxElems)) u_ex (
        .clk(clk), .we(ex_we), .waddr(idx_reg), .wdata(ex_wdata),
        .raddr(idx_reg), .rdata(ex_rdata)
    );

    assign q_pop = (st_reg == StLoad) && q_valid;
    assign el_we = q_pop && q_item.stored;
    assign el_waddr = cnt_reg[IdxW-1:0];

    logic [15:0] n_diff;
    logic [23:0] p_val;
    logic [15:0] k_val;
    logic [15:0] e_val;
    always_comb
    begin
        n_diff = 16'(17'(max_reg) - 17'($signed(el_rdata)));
        p_val = 24'((n369_reg + 32'd128) >> 8);
        k_val = p_val[23:8];
        e_val = (k_val >= 16'd16) ? 16'd0 : (exp_lut(p_val[7:4]) >> k_val[3:0]);
    end
    assign ex_we = (st_reg == StExpCalc);
    assign ex_wdata = e_val;

    logic [SumW:0] rem_try;
    logic [SumW:0] rem_sh;
    always_comb
    begin
        rem_sh = {rem_reg[SumW-1:0], dnum_reg[37]};
        rem_try = rem_sh - {1'b0, sum_reg};
    end

    logic last_idx;
    assign last_idx = (CntW'(idx_reg) + 1'b1) == cnt_reg;

    always_ff @(posedge clk)
    begin
        if (st_reg == StExpMul)
        begin
            n369_reg <= 32'(n_diff) * 32'd369;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= StLoad;
            cnt_reg <= '0;
            idx_reg <= '0;
            max_reg <= 16'sh8000;
            sum_reg <= '0;
            drop_reg <= 1'b0;
            dstep_reg <= '0;
            rem_reg <= '0;
            dnum_reg <= '0;
            quo_reg <= '0;
            prob_reg <= '0;
            fin_reg <= 1'b0;
            ovf_reg <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            unique case (st_reg)
                StLoad:
                begin
                    if (q_pop)
                    begin
                        if (q_item.stored)
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                            if ($signed(q_item.value) > max_reg)
                            begin
                                max_reg <= q_item.value;
                            end
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                        if (q_item.last)
                        begin
                            idx_reg <= '0;
                            sum_reg <= '0;
                            st_reg <= StExpRd;
                        end
                    end
                end
                StExpRd:
                begin
                    // element ram read in flight
                    st_reg <= StExpMul;
                end
                StExpMul:
                begin
                    st_reg <= StExpCalc;
                end
                StExpCalc:
                begin
                    sum_reg <= sum_reg + SumW'(e_val);
                    if (last_idx)
                    begin
                        idx_reg <= '0;
                        st_reg <= StDivRd;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        st_reg <= StExpRd;
                    end
                end
                StDivRd:
                begin
                    // exp ram read in flight
                    st_reg <= StDivLd;
                end
                StDivLd:
                begin
                    // numerator e*65536 + sum/2, restoring divide one bit a cycle
                    dnum_reg <= 38'({ex_rdata, 16'd0}) + 38'(sum_reg >> 1);
                    rem_reg <= '0;
                    quo_reg <= '0;
                    dstep_reg <= '0;
                    st_reg <= StDiv;
                end
                StDiv:
                begin
                    dnum_reg <= {dnum_reg[36:0], 1'b0};
                    if (!rem_try[SumW])
                    begin
                        rem_reg <= rem_try;
                        quo_reg <= {quo_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[15:0], 1'b0};
                    end
                    dstep_reg <= dstep_reg + 1'b1;
                    if (dstep_reg == 6'd37)
                    begin
                        st_reg <= StEmit;
                    end
                end
                StEmit:
                begin
                    if (!oval_reg)
                    begin
                        prob_reg <= quo_reg[16] ? 16'hFFFF : quo_reg[15:0];
                        fin_reg <= last_idx;
                        ovf_reg <= drop_reg;
                        oval_reg <= 1'b1;
                        if (last_idx)
                        begin
                            cnt_reg <= '0;
                            max_reg <= 16'sh8000;
                            drop_reg <= 1'b0;
                            st_reg <= StLoad;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            st_reg <= StDivRd;
                        end
                    end
                end
                default:
                begin
                    st_reg <= StLoad;
                end
            endcase
            if (out_ch.valid && out_ch.ready)
            begin
                oval_reg <= 1'b0;
            end
        end
    end

    assign vec_done = (st_reg == StEmit) && !oval_reg && last_idx;
    assign out_ch.valid = oval_reg;
    assign out_ch.prob = prob_reg;
    assign out_ch.final_res = fin_reg;
    assign out_ch.overflowed = ovf_reg;

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(MaxElems)) else $error("element count over capacity");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (oval_reg && !out_ch.ready) |=> oval_reg) else $error("result dropped");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != StLoad) |-> !q_pop) else $error("queue pop while busy");
endmodule

// ----- hdl/softmax_vector_normalizer_unit.sv -----
// top level of the softmax normalizer: front end, queue, back end
// depends on svn_pkg, svn_if, svn_front, svn_queue, svn_back
//
// Takes one signed Q8.8 element per transfer, up to 32 per vector, and on
// the element marked last emits one unsigned Q0.16 probability per stored
// element in arrival order, with final_res on the last one and overflowed on
// every result if elements past capacity were dropped. After last, the exp
// pass steps through ram read, multiply, and table and shift for each
// element, and the divide pass through ram read, numerator load, 38 restoring
// divider steps and emit for each element; emit waits while the previous
// result is still held on the output. No input is taken after the last
// element until the final result of that vector has been handed to the
// output register.
module softmax_vector_normalizer_unit
    import svn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    svn_in_if.sink     in_ch,
    svn_out_if.source  out_ch
);
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_ne;
    logic        vec_done;
    front_item_t push_item;
    front_item_t pop_item;

    svn_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .vec_done(vec_done),
        .q_push(q_push), .q_item(push_item), .q_full(q_full)
    );

    svn_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_item(push_item),
        .full(q_full), .pop(q_pop), .pop_item(pop_item), .not_empty(q_ne)
    );

    svn_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_item(pop_item),
        .q_pop(q_pop), .vec_done(vec_done), .out_ch(out_ch)
    );
endmodule

// ----- tb/sv/svn_tb_checker.sv -----
// softmax normalizer checker: watches both channels, predicts probabilities, compares
// depends on svn_pkg, svn_if
module svn_tb_checker
    import svn_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    svn_in_if     in_ch,
    svn_out_if    out_ch,
    output int    fail_count,
    output int    pending_count
);
    typedef struct packed {
        logic [15:0] prob;
        logic        final_res;
        logic        overflowed;
    } prob_t;

    localparam logic [15:0] ExpTab [16] = '{
        16'd65535, 16'd62757, 16'd60097, 16'd57549, 16'd55109, 16'd52773,
        16'd50535, 16'd48393, 16'd46341, 16'd44376, 16'd42495, 16'd40693,
        16'd38968, 16'd37316, 16'd35734, 16'd34219
    };

    logic signed [15:0] elems [MaxElems];
    int                 n_elems;
    logic signed [15:0] peak;
    logic               dropped;
    prob_t              expected_probs [$];

    function automatic logic [15:0] exp_of(input logic signed [15:0] x,
                                           input logic signed [15:0] mx);
        logic [15:0] n;
        logic [31:0] p;
        logic [31:0] k;
        n = (mx < x) ? 16'd0 : 16'(mx - x);
        p = (32'(n) * 32'd369 + 32'd128) >> 8;
        k = p >> 8;
        if (k >= 16)
            return 16'd0;
        return ExpTab[p[7:4]] >> k;
    endfunction

    task automatic take_element(input logic signed [15:0] x, input logic lst);
        logic [15:0] e [MaxElems];
        logic [21:0] total;
        logic [63:0] q;
        prob_t r;
        if (n_elems < MaxElems)
        begin
            elems[n_elems] = x;
            n_elems++;
            if (x > peak)
                peak = x;
        end
        else
            dropped = 1'b1;
        if (!lst)
            return;
        total = '0;
        for (int i = 0; i < n_elems; i++)
        begin
            e[i] = exp_of(elems[i], peak);
            total = total + 22'(e[i]);
        end
        for (int i = 0; i < n_elems; i++)
        begin
            q = (64'(e[i]) * 64'd65536 + 64'(total >> 1)) / 64'(total);
            r.prob = (q > 64'd65535) ? 16'hFFFF : q[15:0];
            r.final_res = (i == n_elems - 1);
            r.overflowed = dropped;
            expected_probs.push_back(r);
        end
        n_elems = 0;
        peak = -16'sd32768;
        dropped = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        prob_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            n_elems = 0;
            peak = -16'sd32768;
            dropped = 1'b0;
            expected_probs.delete();
            pending_count = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                take_element(in_ch.value, in_ch.last);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_probs.size() == 0)
                begin
                    $error("unexpected result transfer prob=%0d", out_ch.prob);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_probs.pop_front();
                    if (out_ch.prob !== want.prob || out_ch.final_res !== want.final_res
                        || out_ch.overflowed !== want.overflowed)
                    begin
                        if (out_ch.prob !== want.prob)
                            $error("prob: expected %0d, got %0d", want.prob, out_ch.prob);
                        if (out_ch.final_res !== want.final_res)
                            $error("final_res: expected %0b, got %0b",
                                   want.final_res, out_ch.final_res);
                        if (out_ch.overflowed !== want.overflowed)
                            $error("overflowed: expected %0b, got %0b",
                                   want.overflowed, out_ch.overflowed);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count = expected_probs.size();
        end
    end
endmodule

// ----- tb/sv/tb_softmax_vector_normalizer_unit.sv -----
// testbench top for the softmax normalizer: clock, reset, element stimulus, verdict
// depends on svn_pkg, svn_if, svn_tb_checker, softmax_vector_normalizer_unit
module tb_softmax_vector_normalizer_unit;
    import svn_pkg::*;

    // watchdog limit, sized for the worst case of full vectors with receiver stalls
    localparam int CycleLimit = 400000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count;
    logic sink_busy;

    svn_in_if  in_ch ();
    svn_out_if out_ch ();

    softmax_vector_normalizer_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    svn_tb_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // watchdog on the cycle count
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("** softmax_vector_normalizer_unit: FAILED **");
            $finish;
        end
    end

    // receiver side: random stall before each result transfer,
    // with stall-free stretches while sink_busy is low
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = sink_busy ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // one element transfer after a random sender gap when gaps is set; valid held until accepted
    task automatic send_element(input logic signed [15:0] v, input logic lst,
                                input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= lst;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // drop valid and wait until every expected result has been taken
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
    endtask

    // random vector; values are kept near each other most of the time so the
    // exponent table is actually walked, with wide noise now and then
    task automatic send_vector(input int len, input bit gaps);
        logic signed [15:0] base;
        logic signed [15:0] v;
        int spread;
        base = 16'($urandom);
        spread = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(16, 4096);
        for (int i = 0; i < len; i++)
        begin
            v = (spread == 65535) ? 16'($urandom)
                                  : base + 16'($urandom_range(0, spread)) - 16'(spread / 2);
            send_element(v, i == len - 1, gaps);
        end
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        in_ch.last  = 1'b0;
        cycle_count = 0;
        sink_busy   = 1'b1;
        rst_n       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single-element vector at both extremes
        send_element(16'sh7FFF, 1'b1, 1'b0);
        send_element(-16'sd32768, 1'b1, 1'b0);
        // extremes together: the small one underflows to zero
        send_element(-16'sd32768, 1'b0, 1'b0);
        send_element(16'sh7FFF, 1'b1, 1'b0);
        // equal elements, then small steps that walk the table fraction bits
        send_element(16'sd0, 1'b0, 1'b0);
        send_element(16'sd0, 1'b1, 1'b0);
        send_element(16'sd256, 1'b0, 1'b0);
        send_element(16'sd240, 1'b0, 1'b0);
        send_element(16'sd100, 1'b0, 1'b0);
        send_element(16'sd0, 1'b0, 1'b0);
        send_element(-16'sd1, 1'b1, 1'b0);
        // sender pauses until all results are back
        drain();
        // capacity exceeded: 34 elements, dropped one marked last ends the vector
        for (int i = 0; i < 34; i++)
            send_element(16'(i * 37 - 600), i == 33, 1'b1);
        // exactly full vector, no drop
        send_vector(MaxElems, 1'b1);

        // random vectors, mostly short, a few full or overflowing
        for (int n = 0; n < 85; )
        begin
            int len;
            int pick;
            pick = $urandom_range(0, 19);
            len = (pick == 0) ? $urandom_range(33, 36)
                : (pick == 1) ? MaxElems : $urandom_range(1, 6);
            sink_busy = ($urandom_range(0, 3) != 0);
            send_vector(len, $urandom_range(0, 3) != 0);
            n += len;
        end
        sink_busy = 1'b1;

        drain();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("** softmax_vector_normalizer_unit: PASSED **");
        else
            $display("** softmax_vector_normalizer_unit: FAILED **");
        $finish;
    end
endmodule

// ----- files.f -----
hdl/svn_pkg.sv
hdl/svn_if.sv
hdl/svn_ram.sv
hdl/svn_front.sv
hdl/svn_queue.sv
hdl/svn_back.sv
hdl/softmax_vector_normalizer_unit.sv
tb/sv/svn_tb_checker.sv
tb/sv/tb_softmax_vector_normalizer_unit.sv
